// ----- rtl/core/dfq_pkg.sv -----
// ---------------------------------------------------------------------------
// dfq_pkg: shared types and constants of the deduplicating queue
// Key layout, cell control word, sequencer states and the key clean-up
// function.
// ---------------------------------------------------------------------------
`default_nettype none

package dfq_pkg;

  // key is 63 bytes, byte 0 in bits 7:0
  localparam int KEY_BYTES = 63;
  localparam int KEY_BITS  = 8 * KEY_BYTES;
  localparam int PRIO_BITS = 32;

  typedef logic [KEY_BITS-1:0]         key_t;
  typedef logic signed [PRIO_BITS-1:0] prio_t;

  // request codes
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_POP = 1'b1;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;  // take the neighbor's entry (pop)
    logic load;   // take the new key and priority (append)
    logic upd;    // take the new priority only (update)
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_t;

  // zero every byte after the first zero byte
  function automatic key_t canon_key(input key_t raw);
    key_t res;
    logic ended;
    res   = raw;
    ended = 1'b0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (ended) begin
        res[8*b +: 8] = 8'h00;
      end else if (raw[8*b +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dfq_req_if.sv -----
// ---------------------------------------------------------------------------
// dfq_req_if: request channel of the deduplicating queue
// Valid/ready channel carrying a mode, a 63-byte key and a priority tag.
// ---------------------------------------------------------------------------
`default_nettype none

interface dfq_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] key_word_0;
  logic [63:0] key_word_1;
  logic [63:0] key_word_2;
  logic [63:0] key_word_3;
  logic [63:0] key_word_4;
  logic [63:0] key_word_5;
  logic [63:0] key_word_6;
  logic [55:0] key_word_7;
  logic signed [31:0] priority_req;

  modport source (
    output valid, mode, key_word_0, key_word_1, key_word_2, key_word_3,
           key_word_4, key_word_5, key_word_6, key_word_7, priority_req,
    input  ready
  );

  modport sink (
    input  valid, mode, key_word_0, key_word_1, key_word_2, key_word_3,
           key_word_4, key_word_5, key_word_6, key_word_7, priority_req,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/dfq_rsp_if.sv -----
// ---------------------------------------------------------------------------
// dfq_rsp_if: response channel of the deduplicating queue
// Valid/ready channel carrying the status flag and a popped entry.
// ---------------------------------------------------------------------------
`default_nettype none

interface dfq_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [63:0] out_key_word_0;
  logic [63:0] out_key_word_1;
  logic [63:0] out_key_word_2;
  logic [63:0] out_key_word_3;
  logic [63:0] out_key_word_4;
  logic [63:0] out_key_word_5;
  logic [63:0] out_key_word_6;
  logic [55:0] out_key_word_7;
  logic signed [31:0] out_prio;

  modport source (
    output valid, ok, out_key_word_0, out_key_word_1, out_key_word_2,
           out_key_word_3, out_key_word_4, out_key_word_5, out_key_word_6,
           out_key_word_7, out_prio,
    input  ready
  );

  modport sink (
    input  valid, ok, out_key_word_0, out_key_word_1, out_key_word_2,
           out_key_word_3, out_key_word_4, out_key_word_5, out_key_word_6,
           out_key_word_7, out_prio,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/dfq_cell.sv -----
// ---------------------------------------------------------------------------
// dfq_cell: one queue slot
// Holds a key and priority, compares its key with the broadcast key and
// takes its upper neighbor's entry when the queue pops.
// ---------------------------------------------------------------------------
`default_nettype none

module dfq_cell (
  input  wire logic              clk,
  input  wire dfq_pkg::cell_ctrl_t ctrl,
  input  wire dfq_pkg::key_t     cmp_key,
  input  wire dfq_pkg::prio_t    new_prio,
  input  wire dfq_pkg::key_t     nb_key,
  input  wire dfq_pkg::prio_t    nb_prio,
  output dfq_pkg::key_t          key,
  output dfq_pkg::prio_t         prio,
  output logic                   match
);

  // entry storage; contents are meaningful only while the slot is live
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key  <= nb_key;
      prio <= nb_prio;
    end else if (ctrl.load) begin
      key  <= cmp_key;
      prio <= new_prio;
    end else if (ctrl.upd) begin
      prio <= new_prio;
    end
  end

  // registered key compare, sampled while the store is stable
  always_ff @(posedge clk) begin
    match <= (key == cmp_key);
  end

endmodule

`default_nettype wire

// ----- rtl/core/dedup_fifo_with_priority_tag_core.sv -----
// ---------------------------------------------------------------------------
// dedup_fifo_with_priority_tag_core: deduplicating queue with priority tags
// A row of cells holds the queue, head in cell 0. An add compares the key in every
// cell at once and updates the matching priority, appends at the tail or is refused
// when full; a pop of a non-empty queue returns cell 0 and shifts the row down by one.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+---------------------------------------
//  req     | in  | valid/ready   | mode, key_word_0..7, priority_req
//  rsp     | out | valid/ready   | ok, out_key_word_0..7, out_prio
//
//  Each request passes through capture and key clean-up, parallel key
//  compare in all cells, then update, append or shift.
//  A new request is taken once the previous one has been applied; the
//  response register lets the next request start while a response waits.
//  A stalled response holds the apply step until rsp is taken.
//  Synchronous reset empties the queue; cell contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module dedup_fifo_with_priority_tag_core #(
  parameter int DEPTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  dfq_req_if.sink    req,
  dfq_rsp_if.source  rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  dfq_pkg::state_t state, state_next;

  logic            mode_q;
  dfq_pkg::key_t   key_q;
  dfq_pkg::prio_t  prio_q;
  logic [CW-1:0]   count;

  dfq_pkg::cell_ctrl_t ctrl [DEPTH];
  dfq_pkg::key_t       cell_key [DEPTH];
  dfq_pkg::prio_t      cell_prio [DEPTH];
  dfq_pkg::key_t       nb_key [DEPTH];
  dfq_pkg::prio_t      nb_prio [DEPTH];
  logic [DEPTH-1:0]    match;
  logic [DEPTH-1:0]    live;
  logic [DEPTH-1:0]    hits;

  logic rsp_valid;
  logic apply_go;
  logic hit;
  logic is_pop;
  logic do_pop;
  logic do_append;
  logic not_full;

  // no word is taken while reset is held
  assign req.ready = (state == dfq_pkg::ST_IDLE) && !rst;
  assign rsp.valid = rsp_valid;

  // request capture
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      mode_q <= req.mode;
      prio_q <= req.priority_req;
      key_q  <= dfq_pkg::canon_key({req.key_word_7, req.key_word_6, req.key_word_5,
                                    req.key_word_4, req.key_word_3, req.key_word_2,
                                    req.key_word_1, req.key_word_0});
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    apply_go   = 1'b0;
    case (state)
      dfq_pkg::ST_IDLE: begin
        if (req.valid) state_next = dfq_pkg::ST_CMP;
      end
      dfq_pkg::ST_CMP: begin
        state_next = dfq_pkg::ST_APPLY;
      end
      dfq_pkg::ST_APPLY: begin
        if (!rsp_valid || rsp.ready) begin
          apply_go   = 1'b1;
          state_next = dfq_pkg::ST_IDLE;
        end
      end
      default: state_next = dfq_pkg::ST_IDLE;
    endcase
  end

  // decision from the registered compares
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live[i] = (CW'(i) < count);
    end
  end

  assign hits      = match & live;
  assign hit       = |hits;
  assign is_pop    = (mode_q == dfq_pkg::MODE_POP);
  assign not_full  = (count < CW'(DEPTH));
  assign do_pop    = apply_go && is_pop && (count != '0);
  assign do_append = apply_go && !is_pop && !hit && not_full;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].shift = do_pop;
      ctrl[i].load  = do_append && (CW'(i) == count);
      ctrl[i].upd   = apply_go && !is_pop && hits[i];
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_pop) begin
      count <= count - CW'(1);
    end else if (do_append) begin
      count <= count + CW'(1);
    end
  end

  // cell row, each cell fed by its upper neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == DEPTH - 1) begin : g_top
      assign nb_key[g]  = '0;
      assign nb_prio[g] = '0;
    end else begin : g_mid
      assign nb_key[g]  = cell_key[g+1];
      assign nb_prio[g] = cell_prio[g+1];
    end

    dfq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[g]),
      .cmp_key  (key_q),
      .new_prio (prio_q),
      .nb_key   (nb_key[g]),
      .nb_prio  (nb_prio[g]),
      .key      (cell_key[g]),
      .prio     (cell_prio[g]),
      .match    (match[g])
    );
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      rsp.ok             <= do_pop || (!is_pop && (hit || not_full));
      rsp.out_key_word_0 <= do_pop ? cell_key[0][63:0]    : '0;
      rsp.out_key_word_1 <= do_pop ? cell_key[0][127:64]  : '0;
      rsp.out_key_word_2 <= do_pop ? cell_key[0][191:128] : '0;
      rsp.out_key_word_3 <= do_pop ? cell_key[0][255:192] : '0;
      rsp.out_key_word_4 <= do_pop ? cell_key[0][319:256] : '0;
      rsp.out_key_word_5 <= do_pop ? cell_key[0][383:320] : '0;
      rsp.out_key_word_6 <= do_pop ? cell_key[0][447:384] : '0;
      rsp.out_key_word_7 <= do_pop ? cell_key[0][503:448] : '0;
      rsp.out_prio       <= do_pop ? cell_prio[0] : '0;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue occupancy above depth");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == dfq_pkg::ST_APPLY) |-> $onehot0(hits))
    else $error("key stored in more than one slot");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    do_pop |=> count == $past(count) - CW'(1))
    else $error("pop did not shrink the queue");

  a_no_append_full: assert property (@(posedge clk) disable iff (rst)
    (apply_go && !is_pop && !hit && !not_full) |=> count == CW'(DEPTH))
    else $error("refused add changed occupancy");

  a_rsp_after_apply: assert property (@(posedge clk) disable iff (rst)
    apply_go |=> rsp_valid)
    else $error("applied request produced no response");

endmodule

`default_nettype wire

// ----- bench/tb_dedup_fifo_with_priority_tag_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dedup_fifo_with_priority_tag_core: bench for the deduplicating queue
// Drives add and pop requests through the request channel and checks every
// response against a shadow copy of the queue. A short directed run covers
// the empty and full cases, key clean-up and updates in place. A long random
// run follows, with sender bursts and receiver stalls.
// ---------------------------------------------------------------------------

module tb_dedup_fifo_with_priority_tag_core;

  localparam int    DEPTH       = 16;
  localparam int    RAND_ITEMS  = 1880;
  localparam int    POOL        = 24;
  localparam int    STALL_LIMIT = 2000;
  localparam int    TAIL_CYCLES = 10;
  localparam dfq_pkg::prio_t PRIO_MIN = dfq_pkg::prio_t'(32'h8000_0000);
  localparam dfq_pkg::prio_t PRIO_MAX = dfq_pkg::prio_t'(32'h7fff_ffff);

  // receiver stall styles
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_CHOKE,
    RX_PULSE
  } rx_style_e;

  typedef struct {
    logic           mode;
    dfq_pkg::key_t  key;
    dfq_pkg::prio_t prio;
  } req_word_t;

  typedef struct {
    logic           ok;
    dfq_pkg::key_t  key;
    dfq_pkg::prio_t prio;
  } rsp_word_t;

  typedef struct {
    dfq_pkg::key_t  key;
    dfq_pkg::prio_t prio;
  } entry_t;

  // slice one 64-bit key word, the last one is 56 bits wide
  function automatic logic [63:0] key_word(dfq_pkg::key_t k, int w);
    if (w == 7) return {8'h00, k[448 +: 56]};
    return k[64*w +: 64];
  endfunction

  // -------------------------------------------------------------------------
  // shadow queue and the responses it predicts
  // -------------------------------------------------------------------------
  class dfq_shadow;
    entry_t    held[$];
    rsp_word_t rsp_due[$];
    int        errors;

    // everything past the first zero byte reads as zero
    function dfq_pkg::key_t strip_tail(dfq_pkg::key_t raw);
      dfq_pkg::key_t keep;
      keep = '0;
      for (int b = 0; b < dfq_pkg::KEY_BYTES; b++) begin
        if (raw[8*b +: 8] == 8'h00) break;
        keep[8*b +: 8] = 8'hff;
      end
      return raw & keep;
    endfunction

    function void take_request(req_word_t r);
      rsp_word_t     e;
      entry_t        n;
      dfq_pkg::key_t k;
      bit            hit;
      e.ok   = 1'b0;
      e.key  = '0;
      e.prio = '0;
      hit    = 1'b0;
      if (r.mode == dfq_pkg::MODE_POP) begin
        if (held.size() > 0) begin
          e.ok   = 1'b1;
          e.key  = held[0].key;
          e.prio = held[0].prio;
          held.delete(0);
        end
      end else begin
        k = strip_tail(r.key);
        foreach (held[i]) begin
          if (!hit && held[i].key == k) begin
            held[i].prio = r.prio;
            hit = 1'b1;
          end
        end
        if (hit) begin
          e.ok = 1'b1;
        end else if (held.size() < DEPTH) begin
          n.key  = k;
          n.prio = r.prio;
          held.push_back(n);
          e.ok = 1'b1;
        end
      end
      rsp_due.push_back(e);
    endfunction

    function void match_response(rsp_word_t got);
      rsp_word_t want;
      if (rsp_due.size() == 0) begin
        errors++;
        $display("%0t: response with none pending, ok=%0b", $time, got.ok);
        return;
      end
      want = rsp_due.pop_front();
      if (got.ok !== want.ok) begin
        errors++;
        $display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
      end
      for (int w = 0; w < 8; w++) begin
        if (key_word(got.key, w) !== key_word(want.key, w)) begin
          errors++;
          $display("%0t: out_key_word_%0d expected %h actual %h", $time, w,
                   key_word(want.key, w), key_word(got.key, w));
        end
      end
      if (got.prio !== want.prio) begin
        errors++;
        $display("%0t: out_prio expected %0d actual %0d", $time,
                 want.prio, got.prio);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  dfq_req_if req_ch();
  dfq_rsp_if rsp_ch();

  dedup_fifo_with_priority_tag_core #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  dfq_shadow     sb;
  dfq_pkg::key_t pool_key[POOL];
  int            pool_len[POOL];
  rsp_word_t     mon_word;
  int            quiet;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // key builders
  // -------------------------------------------------------------------------
  function automatic int pick_len();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return $urandom_range(0, 4);
    if (roll < 7) return $urandom_range(5, 20);
    if (roll < 9) return $urandom_range(21, 62);
    return dfq_pkg::KEY_BYTES;
  endfunction

  function automatic dfq_pkg::key_t fresh_key(int len);
    dfq_pkg::key_t k;
    k = '0;
    for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // garbage after the terminator, sometimes
  function automatic dfq_pkg::key_t with_junk(dfq_pkg::key_t base, int len);
    dfq_pkg::key_t k;
    k = base;
    if ($urandom_range(0, 1) == 1) begin
      for (int b = len + 1; b < dfq_pkg::KEY_BYTES; b++) begin
        k[8*b +: 8] = 8'($urandom_range(0, 255));
      end
    end
    return k;
  endfunction

  function automatic dfq_pkg::key_t noise_key();
    dfq_pkg::key_t k;
    k = '0;
    for (int b = 0; b < dfq_pkg::KEY_BYTES; b++) begin
      k[8*b +: 8] = 8'($urandom_range(0, 255));
    end
    return k;
  endfunction

  function automatic req_word_t make_word(logic mode, dfq_pkg::key_t key,
                                          dfq_pkg::prio_t prio);
    req_word_t w;
    w.mode = mode;
    w.key  = key;
    w.prio = prio;
    return w;
  endfunction

  // mostly keys from a small pool so that updates and a full queue happen
  function automatic req_word_t random_word(int add_pct);
    req_word_t w;
    int        pick;
    int        idx;
    int        len;
    w = make_word(dfq_pkg::MODE_ADD, '0, dfq_pkg::prio_t'($urandom));
    if ($urandom_range(0, 99) >= add_pct) begin
      w.mode = dfq_pkg::MODE_POP;
      w.key  = noise_key();
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        idx   = $urandom_range(0, POOL - 1);
        w.key = with_junk(pool_key[idx], pool_len[idx]);
      end else if (pick < 93) begin
        len   = pick_len();
        w.key = with_junk(fresh_key(len), len);
      end else begin
        w.key = noise_key();
      end
    end
    case ($urandom_range(0, 15))
      0: w.prio = PRIO_MIN;
      1: w.prio = PRIO_MAX;
      2: w.prio = '0;
      default: ;
    endcase
    return w;
  endfunction

  // -------------------------------------------------------------------------
  // request driver
  // -------------------------------------------------------------------------
  task automatic send_word(req_word_t w);
    req_ch.mode         <= w.mode;
    req_ch.key_word_0   <= w.key[0 +: 64];
    req_ch.key_word_1   <= w.key[64 +: 64];
    req_ch.key_word_2   <= w.key[128 +: 64];
    req_ch.key_word_3   <= w.key[192 +: 64];
    req_ch.key_word_4   <= w.key[256 +: 64];
    req_ch.key_word_5   <= w.key[320 +: 64];
    req_ch.key_word_6   <= w.key[384 +: 64];
    req_ch.key_word_7   <= w.key[448 +: 56];
    req_ch.priority_req <= w.prio;
    req_ch.valid        <= 1'b1;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sb.take_request(w);
  endtask

  task automatic idle_for(int cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------
  initial begin
    dfq_pkg::key_t all_ff;
    dfq_pkg::key_t k;
    int            burst_left;
    int            add_pct;
    all_ff     = '1;
    burst_left = 0;
    add_pct    = 60;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.mode         <= dfq_pkg::MODE_ADD;
    req_ch.key_word_0   <= '0;
    req_ch.key_word_1   <= '0;
    req_ch.key_word_2   <= '0;
    req_ch.key_word_3   <= '0;
    req_ch.key_word_4   <= '0;
    req_ch.key_word_5   <= '0;
    req_ch.key_word_6   <= '0;
    req_ch.key_word_7   <= '0;
    req_ch.priority_req <= '0;
    sb = new;
    for (int i = 0; i < POOL; i++) begin
      pool_len[i] = pick_len();
      pool_key[i] = fresh_key(pool_len[i]);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pop on empty, empty key, empty key with trailing junk, full-length key
    send_word(make_word(dfq_pkg::MODE_POP, noise_key(), PRIO_MAX));
    send_word(make_word(dfq_pkg::MODE_ADD, '0, PRIO_MIN));
    k = noise_key();
    k[7:0] = 8'h00;
    send_word(make_word(dfq_pkg::MODE_ADD, k, PRIO_MAX));
    send_word(make_word(dfq_pkg::MODE_ADD, all_ff, '0));
    send_word(make_word(dfq_pkg::MODE_POP, '0, '0));

    // fill to DEPTH with distinct lengths, then refuse a new key
    for (int i = 0; i < DEPTH - 1; i++) begin
      send_word(make_word(dfq_pkg::MODE_ADD,
                          with_junk(fresh_key(4*i + 2), 4*i + 2),
                          dfq_pkg::prio_t'(i - 8)));
    end
    send_word(make_word(dfq_pkg::MODE_ADD, '0, PRIO_MIN));
    // update in place while full, then see it come out first
    send_word(make_word(dfq_pkg::MODE_ADD, all_ff, dfq_pkg::prio_t'(-1)));
    send_word(make_word(dfq_pkg::MODE_POP, noise_key(), '0));

    // random traffic in bursts, add/pop mix shifts every so often
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 4) != 0) idle_for($urandom_range(1, 15));
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if (n % 150 == 0) add_pct = $urandom_range(25, 85);
      send_word(random_word(add_pct));
    end
    req_ch.valid <= 1'b0;

    while (sb.rsp_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // receiver: ready follows a style that changes now and then
  // -------------------------------------------------------------------------
  initial begin
    rx_style_e style;
    int        span;
    style = RX_OPEN;
    span  = 0;
    forever begin
      if (span == 0) begin
        style = rx_style_e'($urandom_range(0, 3));
        span  = $urandom_range(20, 300);
      end
      span--;
      case (style)
        RX_OPEN:  rsp_ch.ready <= 1'b1;
        RX_COIN:  rsp_ch.ready <= ($urandom_range(0, 1) == 1);
        RX_CHOKE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default:  rsp_ch.ready <= ((span % 8) < 3);
      endcase
      @(posedge clk);
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      mon_word.ok   = rsp_ch.ok;
      mon_word.key  = {rsp_ch.out_key_word_7, rsp_ch.out_key_word_6,
                       rsp_ch.out_key_word_5, rsp_ch.out_key_word_4,
                       rsp_ch.out_key_word_3, rsp_ch.out_key_word_2,
                       rsp_ch.out_key_word_1, rsp_ch.out_key_word_0};
      mon_word.prio = rsp_ch.out_prio;
      sb.match_response(mon_word);
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
rtl/core/dfq_pkg.sv
rtl/core/dfq_req_if.sv
rtl/core/dfq_rsp_if.sv
rtl/core/dfq_cell.sv
rtl/core/dedup_fifo_with_priority_tag_core.sv
bench/tb_dedup_fifo_with_priority_tag_core.sv
